/* rtl/core/chip8_instruction_execute_macros.svh */
// assertion macros for the chip-8 execute core
// no dependencies
`ifndef CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
`define CHIP8_INSTRUCTION_EXECUTE_MACROS_SVH
// property checked every clock outside reset
`define C8_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// property checked at every clock, reset included
`define C8_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

/* rtl/core/c8_pkg.sv */
// types and codes shared by the chip-8 execute core
// no dependencies
`default_nettype none
package c8_pkg;
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_EXEC  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UNSUP = 2'd1;
    localparam logic [1:0] ST_OVER  = 2'd2;
    localparam logic [1:0] ST_UNDER = 2'd3;

    localparam logic [11:0] PC_RESET = 12'd512;

    typedef struct packed {
        logic [1:0]  command;
        logic [11:0] address;
        logic [7:0]  data;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
        logic [7:0]  random_byte;
    } t_in_item;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [4:0]  stack_depth;
        logic [7:0]  flag_register;
        logic [1:0]  status;
        logic        pixel_value;
        logic [15:0] executed_opcode;
    } t_out_item;

    // alu operation codes for the shared byte unit
    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_RSB = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    typedef struct packed {
        logic [7:0] value;
        logic       flag;
        logic       valid;
    } t_alu_res;
endpackage
`default_nettype wire

/* rtl/core/c8_alu.sv */
// shared byte arithmetic unit of the chip-8 core
// depends on c8_pkg
`default_nettype none
module c8_alu (
    input  wire logic [3:0] i_op,
    input  wire logic [7:0] i_a,
    input  wire logic [7:0] i_b,
    output c8_pkg::t_alu_res o_res
);
    logic [8:0] w_sum;
    logic [8:0] w_dif;
    logic [8:0] w_rdf;

    assign w_sum = {1'b0, i_a} + {1'b0, i_b};
    assign w_dif = {1'b0, i_a} - {1'b0, i_b};
    assign w_rdf = {1'b0, i_b} - {1'b0, i_a};

    // one operation per cycle, flag is carry, no-borrow or shifted-out bit
    always_comb begin
        o_res = '0;
        o_res.valid = 1'b1;
        unique case (i_op)
            c8_pkg::ALU_MOV: o_res.value = i_b;
            c8_pkg::ALU_OR:  o_res.value = i_a | i_b;
            c8_pkg::ALU_AND: o_res.value = i_a & i_b;
            c8_pkg::ALU_XOR: o_res.value = i_a ^ i_b;
            c8_pkg::ALU_ADD: begin
                o_res.value = w_sum[7:0];
                o_res.flag  = w_sum[8];
            end
            c8_pkg::ALU_SUB: begin
                o_res.value = w_dif[7:0];
                o_res.flag  = ~w_dif[8];
            end
            c8_pkg::ALU_SHR: begin
                o_res.value = {1'b0, i_a[7:1]};
                o_res.flag  = i_a[0];
            end
            c8_pkg::ALU_RSB: begin
                o_res.value = w_rdf[7:0];
                o_res.flag  = ~w_rdf[8];
            end
            c8_pkg::ALU_SHL: begin
                o_res.value = {i_a[6:0], 1'b0};
                o_res.flag  = i_a[7];
            end
            default: o_res.valid = 1'b0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/chip8_instruction_execute.sv */
// chip-8 execute core: takes a memory write, a pixel read, an instruction to execute or a no-op,
// and reports the result with o_done
// one item at a time: busy is high from start until the result strobe
// the clear sweep and the DXYN pixel walk (read, then write each pixel) set how long an item takes
// after reset a sweep over all SCREEN_W*SCREEN_H pixels clears the frame; busy is high meanwhile
// the receiver cannot stall: each result shows for one cycle with o_done
`default_nettype none
`include "chip8_instruction_execute_macros.svh"
module chip8_instruction_execute #(
    parameter int MEM_BYTES   = 4096,
    parameter int STACK_DEPTH = 16,
    parameter int SCREEN_W    = 64,
    parameter int SCREEN_H    = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire c8_pkg::t_in_item  i_item,
    output logic                   o_done,
    output c8_pkg::t_out_item      o_item,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [11:0]       i_cfg_data
);
    localparam int MA  = $clog2(MEM_BYTES);
    localparam int SA  = $clog2(STACK_DEPTH);
    localparam int XW  = $clog2(SCREEN_W);
    localparam int YW  = $clog2(SCREEN_H);
    localparam int FA  = $clog2(SCREEN_W * SCREEN_H);
    localparam int FN  = SCREEN_W * SCREEN_H;
    localparam int SPW = $clog2(STACK_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FET0  = 4'd2;
    localparam logic [3:0] S_FET1  = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_EXE   = 4'd5;
    localparam logic [3:0] S_CLS   = 4'd6;
    localparam logic [3:0] S_ROWRD = 4'd7;
    localparam logic [3:0] S_ROWWT = 4'd8;
    localparam logic [3:0] S_PXRD  = 4'd9;
    localparam logic [3:0] S_PXWR  = 4'd10;
    localparam logic [3:0] S_PIX   = 4'd11;
    localparam logic [3:0] S_PIXWT = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]  r_state;
    logic [3:0]  n_state;
    c8_pkg::t_in_item r_in;
    logic [7:0]  r_mem [MEM_BYTES];
    logic [11:0] r_stk [STACK_DEPTH];
    logic        r_frm [FN];
    logic [7:0]  r_mem_q;
    logic [11:0] r_stk_q;
    logic        r_frm_q;
    logic [7:0]  r_v [16];
    logic [11:0] r_pc;
    logic [11:0] n_pc;
    logic [11:0] r_i;
    logic [SPW-1:0] r_sp;
    logic [15:0] r_op;
    logic [1:0]  r_st;
    logic        r_pix;
    logic [FA:0] r_cnt;
    logic [3:0]  r_row;
    logic [2:0]  r_col;
    logic [7:0]  r_rowbits;
    logic        r_hit;
    logic        r_done;

    // memory and frame addressing
    logic [11:0] w_maddr12;
    logic [MA-1:0] w_maddr;
    logic        w_mwe;
    logic [FA-1:0] w_faddr;
    logic        w_fwe;
    logic        w_fd;
    logic [7:0]  w_x0;
    logic [7:0]  w_y0;
    logic [XW-1:0] w_px;
    logic [YW-1:0] w_py;
    logic [11:0] w_pc2;
    logic [3:0]  w_x;
    logic [3:0]  w_y;
    c8_pkg::t_alu_res w_alu;
    logic [3:0]  w_aop;
    logic [7:0]  w_aa;
    logic [7:0]  w_ab;

    assign w_x   = r_op[11:8];
    assign w_y   = r_op[7:4];
    assign w_pc2 = r_pc + 12'd2;
    assign w_x0  = r_v[w_x];
    assign w_y0  = r_v[w_y];

    // shared unit: alu ops and the 7XNN add share it by operand choice
    always_comb begin
        w_aop = r_op[3:0];
        w_aa  = w_x0;
        w_ab  = w_y0;
        if (r_op[15:12] == 4'h7) begin
            w_aop = c8_pkg::ALU_ADD;
            w_ab  = r_op[7:0];
        end
    end

    c8_alu u_alu (.i_op(w_aop), .i_a(w_aa), .i_b(w_ab), .o_res(w_alu));

    // memory address: write, fetch bytes, sprite rows
    always_comb begin
        unique case (r_state)
            S_FET0:  w_maddr12 = r_pc;
            S_FET1:  w_maddr12 = r_pc + 12'd1;
            default: w_maddr12 = r_i + {8'd0, r_row};
        endcase
        if (r_state == S_IDLE) w_maddr12 = i_item.address;
    end
    // memory size is a power of two: low bits wrap, a larger memory sees the 12-bit address
    assign w_maddr = MA'(w_maddr12);
    assign w_mwe   = (r_state == S_IDLE) && start && (i_item.command == c8_pkg::CMD_WRITE);

    // pixel coordinate with wrap; screen sizes are powers of two
    always_comb begin
        if (r_state == S_PIX || r_state == S_PIXWT) begin
            w_px = XW'(r_in.pixel_x);
            w_py = YW'(r_in.pixel_y);
        end else begin
            w_px = XW'(w_x0 + {5'd0, r_col});
            w_py = YW'(w_y0 + {4'd0, r_row});
        end
    end

    always_comb begin
        w_faddr = FA'({w_py, w_px});
        w_fwe   = 1'b0;
        w_fd    = 1'b0;
        if (r_state == S_CLEAR || r_state == S_CLS) begin
            w_faddr = r_cnt[FA-1:0];
            w_fwe   = 1'b1;
        end else if (r_state == S_PXWR) begin
            w_fwe = r_rowbits[3'd7 - r_col];
            w_fd  = ~r_frm_q;
        end
    end

    // memories with registered reads
    always_ff @(posedge i_clk) begin
        if (w_mwe) r_mem[w_maddr] <= i_item.data;
        r_mem_q <= r_mem[w_maddr];
        if (w_fwe) r_frm[w_faddr] <= w_fd;
        r_frm_q <= r_frm[w_faddr];
        r_stk_q <= r_stk[SA'(r_sp - SPW'(1))];
        if (r_state == S_EXE && r_op[15:12] == 4'h2 && r_sp < SPW'(STACK_DEPTH))
            r_stk[SA'(r_sp)] <= r_pc;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_cnt == (FA+1)'(FN - 1)) n_state = S_IDLE;
            S_IDLE: if (start) begin
                unique case (i_item.command)
                    c8_pkg::CMD_EXEC:  n_state = S_FET0;
                    c8_pkg::CMD_PIXEL: n_state = S_PIX;
                    default:           n_state = S_DONE;
                endcase
            end
            S_FET0:  n_state = S_FET1;
            S_FET1:  n_state = S_DEC;
            S_DEC:   n_state = S_EXE;
            S_EXE: begin
                if (r_op == 16'h00E0) n_state = S_CLS;
                else if (r_op[15:12] == 4'hD && r_op[3:0] != 4'd0) n_state = S_ROWRD;
                else n_state = S_DONE;
            end
            S_CLS:   if (r_cnt == (FA+1)'(FN - 1)) n_state = S_DONE;
            S_ROWRD: n_state = S_ROWWT;
            S_ROWWT: n_state = S_PXRD;
            S_PXRD:  n_state = S_PXWR;
            S_PXWR: begin
                if (r_col != 3'd7) n_state = S_PXRD;
                else if (r_row == r_op[3:0] - 4'd1) n_state = S_DONE;
                else n_state = S_ROWRD;
            end
            S_PIX:   n_state = S_PIXWT;
            S_PIXWT: n_state = S_DONE;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // pc after the instruction: step by two unless a jump, call or return takes it
    always_comb begin
        n_pc = w_pc2;
        unique case (r_op[15:12])
            4'h0: if (r_op[11:0] == 12'h0EE && r_sp != '0) n_pc = r_stk_q + 12'd2;
            4'h1: n_pc = r_op[11:0];
            4'h2: if (r_sp < SPW'(STACK_DEPTH)) n_pc = r_op[11:0];
            4'hB: n_pc = r_op[11:0] + {4'd0, r_v[0]};
            default: ;
        endcase
    end

    // sequencer and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_pc    <= c8_pkg::PC_RESET;
            r_i     <= '0;
            r_sp    <= '0;
            r_done  <= 1'b0;
            for (int k = 0; k < 16; k++) r_v[k] <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_DONE);
            if (i_cfg_valid && o_cfg_ready) begin
                r_pc    <= i_cfg_data;
            end
            unique case (r_state)
                S_CLEAR, S_CLS: r_cnt <= r_cnt + 1'b1;
                S_IDLE: if (start) begin
                    r_in  <= i_item;
                    r_op  <= '0;
                    r_st  <= c8_pkg::ST_OK;
                    r_pix <= 1'b0;
                    r_cnt <= '0;
                end
                S_FET1: r_op[15:8] <= r_mem_q;
                S_DEC:  r_op[7:0]  <= r_mem_q;
                S_EXE: begin
                    r_row <= '0;
                    r_col <= '0;
                    r_hit <= 1'b0;
                    r_pc  <= n_pc;
                    unique case (r_op[15:12])
                        4'h0: begin
                            if (r_op[11:0] == 12'h0EE) begin
                                if (r_sp == '0) r_st <= c8_pkg::ST_UNDER;
                                else r_sp <= r_sp - 1'b1;
                            end else if (r_op[11:0] != 12'h0E0) r_st <= c8_pkg::ST_UNSUP;
                        end
                        4'h1: ;
                        4'h2: begin
                            if (r_sp >= SPW'(STACK_DEPTH)) r_st <= c8_pkg::ST_OVER;
                            else r_sp <= r_sp + 1'b1;
                        end
                        4'h6: r_v[w_x] <= r_op[7:0];
                        4'h7: r_v[w_x] <= w_alu.value;
                        4'h8: begin
                            if (!w_alu.valid) r_st <= c8_pkg::ST_UNSUP;
                            else if (r_op[3:0] > 4'h3) begin
                                // flag wins when the destination is VF
                                r_v[15] <= {7'd0, w_alu.flag};
                                if (w_x != 4'hF) r_v[w_x] <= w_alu.value;
                            end else r_v[w_x] <= w_alu.value;
                        end
                        4'hA: r_i <= r_op[11:0];
                        4'hB: ;
                        4'hC: r_v[w_x] <= r_in.random_byte & r_op[7:0];
                        4'hD: if (r_op[3:0] == 4'd0) r_v[15] <= '0;
                        default: r_st <= c8_pkg::ST_UNSUP;
                    endcase
                end
                S_ROWWT: begin
                    r_rowbits <= r_mem_q;
                    r_col     <= '0;
                end
                S_PXWR: begin
                    if (w_fwe && r_frm_q) r_hit <= 1'b1;
                    r_col <= r_col + 1'b1;
                    if (r_col == 3'd7) begin
                        r_row <= r_row + 1'b1;
                        if (r_row == r_op[3:0] - 4'd1)
                            r_v[15] <= {7'd0, r_hit | (w_fwe & r_frm_q)};
                    end
                end
                S_PIXWT: r_pix <= r_frm_q;
                default: ;
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !start;
    assign o_done      = r_done;

    // result fields are live state after the item
    always_comb begin
        o_item.program_counter = r_pc;
        o_item.index_value     = r_i;
        o_item.stack_depth     = 5'(r_sp);
        o_item.flag_register   = r_v[15];
        o_item.status          = r_st;
        o_item.pixel_value     = r_pix;
        o_item.executed_opcode = r_op;
    end

    `C8_ASSERT(a_sp_range, i_clk, i_rst_n, r_sp <= SPW'(STACK_DEPTH), "stack pointer out of range")
    `C8_ASSERT(a_done_idle, i_clk, i_rst_n, o_done |-> !busy, "result while busy")
    `C8_ASSERT(a_start_busy, i_clk, i_rst_n, (start && !busy) |=> busy, "item taken but not busy")
    `C8_ASSERT_ALWAYS(a_rst_busy, i_clk, !i_rst_n |=> busy, "not busy after reset")
endmodule
`default_nettype wire
